[hw/rtl/mesr_pkg.sv]
`timescale 1ns / 1ps
package mesr_pkg;
    localparam int CoordBits  = 12;
    localparam int RadiusBits = 10;
    localparam int OutBits    = CoordBits + 1;
    localparam int StepBits   = RadiusBits + 1;
    localparam int SqBits     = 2 * RadiusBits;
    localparam int TermBits   = 48;
    localparam int ColorBits  = 24;
    localparam int HkBits     = StepBits + 2;   // 2x+1 and y-1 of region two entry
    localparam int ProdBits   = 36;             // partial products of region two entry

    localparam logic [0:0] CfgBoundary = 1'b0;
    localparam logic [0:0] CfgInterior = 1'b1;

    localparam logic KindStart   = 1'b0;
    localparam logic KindAdvance = 1'b1;

    // datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,     // latch item, square radius x
        OP_SQ_B,     // square radius y
        OP_INIT_Y,   // slope_y_term, 4*b^2 + a^2
        OP_INIT_D,   // decision term, region test
        OP_R2_H,     // region two entry: rb2 * h
        OP_R2_HH,    // ... * h
        OP_R2_K,     // 4 ra2 * k
        OP_R2_KK,    // ... * k
        OP_R2_AB,    // 4 ra2 * rb2, combine
        OP_UPDATE    // one midpoint step
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] emit_sel;
    } t_cmd;

    typedef struct packed {
        logic       region_one;  // slope_x < slope_y
        logic       step_y_neg;
        logic       last_step;   // region two with y at zero: this step ends the ellipse
        logic       span_ok;
        logic [3:0] quads;
    } t_status;

    localparam logic [2:0] SelSpanA = 3'd0;
    localparam logic [2:0] SelSpanB = 3'd1;
    localparam logic [2:0] SelPtQ1  = 3'd2;
    localparam logic [2:0] SelPtQ2  = 3'd3;
    localparam logic [2:0] SelPtQ4  = 3'd4;
    localparam logic [2:0] SelPtQ3  = 3'd5;
endpackage

[hw/rtl/mesr_datapath.sv]
`timescale 1ns / 1ps
module mesr_datapath
    import mesr_pkg::*;
(
    input  logic                        i_clk,
    input  t_cmd                        i_cmd,
    input  logic signed [CoordBits-1:0] i_center_x,
    input  logic signed [CoordBits-1:0] i_center_y,
    input  logic [RadiusBits-1:0]       i_radius_x,
    input  logic [RadiusBits-1:0]       i_radius_y,
    input  logic [3:0]                  i_quadrant_mask,
    output t_status                     o_status,
    output logic signed [OutBits-1:0]   o_ax,
    output logic signed [OutBits-1:0]   o_ay,
    output logic signed [OutBits-1:0]   o_bx,
    output logic signed [OutBits-1:0]   o_by
);
    logic signed [StepBits-1:0]  r_px, r_py;
    logic signed [TermBits-1:0]  r_sx, r_sy, r_d, r_acc, r_prod;
    logic signed [CoordBits-1:0] r_cx, r_cy;
    logic [RadiusBits-1:0]       r_rb;
    logic [SqBits-1:0]           r_ra2, r_rb2;
    logic [3:0]                  r_q;

    logic signed [SqBits:0]     ra2_e, rb2_e;
    logic signed [RadiusBits:0] rb_e;
    logic signed [HkBits-1:0]   h_e, k_e;
    logic signed [ProdBits-1:0] prod_s;
    logic signed [TermBits-1:0] sx_n, sy_n, d_n;
    logic signed [StepBits-1:0] px_n, py_n;
    logic qa, qb, qc, qd;

    assign ra2_e  = $signed({1'b0, r_ra2});
    assign rb2_e  = $signed({1'b0, r_rb2});
    assign rb_e   = $signed({1'b0, r_rb});
    assign h_e    = HkBits'(2 * r_px + 1);
    assign k_e    = HkBits'(r_py - 1);
    assign prod_s = $signed(r_prod[ProdBits-1:0]);
    assign {qd, qc, qb, qa} = r_q;

    // one midpoint step
    always_comb begin
        px_n = r_px;
        py_n = r_py;
        sx_n = r_sx;
        sy_n = r_sy;
        d_n  = r_d;
        if (r_sx < r_sy) begin
            px_n = r_px + 1'b1;
            sx_n = r_sx + 2 * rb2_e;
            if (r_d < 0) begin
                d_n = r_d + 4 * sx_n + 4 * rb2_e;
            end else begin
                py_n = r_py - 1'b1;
                sy_n = r_sy - 2 * ra2_e;
                d_n  = r_d + 4 * sx_n - 4 * sy_n + 4 * rb2_e;
            end
        end else begin
            py_n = r_py - 1'b1;
            sy_n = r_sy - 2 * ra2_e;
            if (r_d > 0) begin
                d_n = r_d + 4 * ra2_e - 4 * sy_n;
            end else begin
                px_n = r_px + 1'b1;
                sx_n = r_sx + 2 * rb2_e;
                d_n  = r_d + 4 * sx_n - 4 * sy_n + 4 * ra2_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_cx   <= i_center_x;
                r_cy   <= i_center_y;
                r_q    <= i_quadrant_mask;
                r_rb   <= i_radius_y;
                r_px   <= '0;
                r_py   <= StepBits'($signed({1'b0, i_radius_y}));
                r_sx   <= '0;
                r_ra2  <= i_radius_x * i_radius_x;
            end
            OP_SQ_B: begin
                r_rb2  <= r_rb * r_rb;
                r_prod <= ra2_e * rb_e;
            end
            OP_INIT_Y: begin
                r_sy  <= 2 * r_prod;
                r_acc <= 4 * rb2_e + ra2_e;
            end
            OP_INIT_D: r_d <= r_acc - 4 * r_prod;
            OP_R2_H:   r_prod <= rb2_e * h_e;
            OP_R2_HH:  r_acc <= prod_s * h_e;
            OP_R2_K:   r_prod <= 4 * ra2_e * k_e;
            OP_R2_KK:  r_acc <= r_acc + prod_s * k_e;
            OP_R2_AB:  r_d <= r_acc - 4 * (ra2_e * rb2_e);
            OP_UPDATE: begin
                r_px <= px_n;
                r_py <= py_n;
                r_sx <= sx_n;
                r_sy <= sy_n;
                r_d  <= d_n;
            end
            default: ;
        endcase
    end

    // output selection
    logic signed [OutBits-1:0] px, py, cx, cy, lo, hi, c1, c2;
    logic region_one;
    assign px = OutBits'(r_px);
    assign py = OutBits'(r_py);
    assign cx = OutBits'(r_cx);
    assign cy = OutBits'(r_cy);
    assign region_one = r_sx < r_sy;

    always_comb begin
        if (region_one) begin
            lo = (qc || qd) ? 1 - py : 1;
            hi = (qa || qb) ? py : 0;
            c1 = ((qa || qd) ? px : 0) + cx;
            c2 = ((qb || qc) ? -px : 0) + cx;
        end else begin
            lo = (qb || qc) ? 1 - px : 1;
            hi = (qa || qd) ? px : 0;
            c1 = ((qa || qb) ? py : 0) + cy;
            c2 = ((qc || qd) ? -py : 0) + cy;
        end
        o_ax = px + cx;
        o_ay = py + cy;
        case (i_cmd.emit_sel)
            SelSpanA, SelSpanB: begin
                if (region_one) begin
                    o_ax = (i_cmd.emit_sel == SelSpanA) ? c1 : c2;
                    o_ay = lo + cy;
                    o_bx = o_ax;
                    o_by = hi - 1 + cy;
                end else begin
                    o_ay = (i_cmd.emit_sel == SelSpanA) ? c1 : c2;
                    o_ax = lo + cx;
                    o_by = o_ay;
                    o_bx = hi - 1 + cx;
                end
            end
            SelPtQ1: begin o_ax = cx + px; o_ay = cy + py; o_bx = o_ax; o_by = o_ay; end
            SelPtQ2: begin o_ax = cx - px; o_ay = cy + py; o_bx = o_ax; o_by = o_ay; end
            SelPtQ4: begin o_ax = cx + px; o_ay = cy - py; o_bx = o_ax; o_by = o_ay; end
            SelPtQ3: begin o_ax = cx - px; o_ay = cy - py; o_bx = o_ax; o_by = o_ay; end
            default: begin o_bx = o_ax; o_by = o_ay; end
        endcase
    end

    assign o_status.region_one = region_one;
    assign o_status.step_y_neg = r_py < 0;
    // region one never ends the ellipse; region two always steps y down
    assign o_status.last_step  = !region_one && (r_py == '0);
    assign o_status.span_ok    = lo < hi;
    assign o_status.quads      = r_q;
endmodule

[hw/rtl/mesr_ctrl.sv]
`timescale 1ns / 1ps
module mesr_ctrl
    import mesr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_kind,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_res_load,
    output logic    o_res_fill,
    output logic    o_res_last,
    input  logic    i_res_free
);
    typedef enum logic [3:0] {
        S_IDLE, S_SQ_B, S_INIT_Y, S_INIT_D, S_CHECK,
        S_R2_H, S_R2_HH, S_R2_K, S_R2_KK, S_R2_AB, S_SETTLE,
        S_EMIT, S_UPDATE, S_FINAL
    } t_state;

    t_state     r_state, n_state;
    logic       r_active, n_active;  // an ellipse is loaded and not done
    logic       r_in_r2, n_in_r2;
    logic       r_adv, n_adv;        // region setup reached from an advance
    logic [2:0] r_sel, n_sel;
    logic [5:0] r_pend, n_pend;      // results left to show this iteration
    logic [5:0] pend_init;
    logic       fire;
    logic [2:0] next_sel;

    assign o_ready = (r_state == S_IDLE);
    assign fire    = i_valid && o_ready;

    always_comb begin
        pend_init = {i_status.quads[2], i_status.quads[3], i_status.quads[1],
                     i_status.quads[0], {2{i_status.span_ok}}};
        next_sel = SelPtQ3;
        for (int j = 5; j >= 0; j--) begin
            if (r_pend[j] && 3'(j) > r_sel) next_sel = 3'(j);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_active   = r_active;
        n_in_r2    = r_in_r2;
        n_adv      = r_adv;
        n_sel      = r_sel;
        n_pend     = r_pend;
        o_cmd.op   = OP_NONE;
        o_cmd.emit_sel = r_sel;
        o_res_load = 1'b0;
        o_res_fill = r_sel < SelPtQ1;
        o_res_last = 1'b0;
        case (r_state)
            S_IDLE: if (fire) begin
                if (i_kind == KindStart) begin
                    o_cmd.op = OP_LOAD;
                    n_active = 1'b1;
                    n_in_r2  = 1'b0;
                    n_adv    = 1'b0;
                    n_state  = S_SQ_B;
                end else if (r_active) begin
                    n_state = S_EMIT;
                    n_pend  = pend_init;
                    n_sel   = 3'd0;
                    for (int j = 5; j >= 0; j--) begin
                        if (pend_init[j]) n_sel = 3'(j);
                    end
                end
            end
            S_SQ_B:   begin o_cmd.op = OP_SQ_B;   n_state = S_INIT_Y; end
            S_INIT_Y: begin o_cmd.op = OP_INIT_Y; n_state = S_INIT_D; end
            S_INIT_D: begin o_cmd.op = OP_INIT_D; n_state = S_CHECK; end
            S_CHECK: begin
                if (!r_in_r2 && !i_status.region_one) begin
                    n_in_r2 = 1'b1;
                    n_state = S_R2_H;
                end else begin
                    n_state = S_SETTLE;
                end
            end
            S_R2_H:  begin o_cmd.op = OP_R2_H;  n_state = S_R2_HH; end
            S_R2_HH: begin o_cmd.op = OP_R2_HH; n_state = S_R2_K; end
            S_R2_K:  begin o_cmd.op = OP_R2_K;  n_state = S_R2_KK; end
            S_R2_KK: begin o_cmd.op = OP_R2_KK; n_state = S_R2_AB; end
            S_R2_AB: begin o_cmd.op = OP_R2_AB; n_state = S_SETTLE; end
            S_SETTLE: begin
                if (r_in_r2 && i_status.step_y_neg) n_active = 1'b0;
                n_state = r_adv ? S_FINAL : S_IDLE;
            end
            S_EMIT: begin
                if (r_pend == '0) begin
                    n_state = S_UPDATE;
                end else if (i_res_free) begin
                    o_cmd.emit_sel = r_sel;
                    o_res_load = 1'b1;
                    o_res_last = (r_pend & ~(6'd1 << r_sel)) == '0;
                    n_pend = r_pend & ~(6'd1 << r_sel);
                    n_sel  = next_sel;
                end
            end
            S_UPDATE: begin
                o_cmd.op = OP_UPDATE;
                n_adv    = 1'b1;
                n_state  = S_CHECK;
            end
            S_FINAL: begin
                n_adv   = 1'b0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_in_r2  <= 1'b0;
            r_adv    <= 1'b0;
            r_sel    <= '0;
            r_pend   <= '0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_in_r2  <= n_in_r2;
            r_adv    <= n_adv;
            r_sel    <= n_sel;
            r_pend   <= n_pend;
        end
    end
endmodule

[hw/rtl/mesr_out_buf.sv]
`timescale 1ns / 1ps
module mesr_out_buf
    import mesr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic signed [OutBits-1:0] i_ax,
    input  logic signed [OutBits-1:0] i_ay,
    input  logic signed [OutBits-1:0] i_bx,
    input  logic signed [OutBits-1:0] i_by,
    input  logic                      i_fill,
    input  logic [ColorBits-1:0]      i_color,
    input  logic                      i_last,
    input  logic                      i_done,
    output logic                      o_free,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [OutBits-1:0] o_ax,
    output logic signed [OutBits-1:0] o_ay,
    output logic signed [OutBits-1:0] o_bx,
    output logic signed [OutBits-1:0] o_by,
    output logic                      o_fill,
    output logic [ColorBits-1:0]      o_color,
    output logic                      o_last,
    output logic                      o_done
);
    logic r_valid;
    assign o_valid = r_valid;
    assign o_free  = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_ax    <= i_ax;
            o_ay    <= i_ay;
            o_bx    <= i_bx;
            o_by    <= i_by;
            o_fill  <= i_fill;
            o_color <= i_color;
            o_last  <= i_last;
            o_done  <= i_done;
        end
    end
endmodule

[hw/rtl/midpoint_ellipse_span_raster.sv]
`timescale 1ns / 1ps
// Channel | Signals                                   | Direction
// input   | i_valid/o_ready, kind, centre, radii, mask | in
// result  | o_valid/i_ready, span ends, fill, colour    | out
// config  | i_cfg_we, i_cfg_index, i_cfg_data          | in
// A start loads the item and forms the initial terms. Either request runs
// the region-two setup on entering region two, where the setup products
// run one a cycle. An advance first shows up to 6 results, then updates.
// Results are shown one a cycle from a single output register; a stalled
// result holds the controller in its emit step.
// Reset is synchronous; the block comes up idle with default colours.
// The finished flag is known before the first result of an advance is built.
module midpoint_ellipse_span_raster
    import mesr_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic signed [CoordBits-1:0]   i_center_x,
    input  logic signed [CoordBits-1:0]   i_center_y,
    input  logic [RadiusBits-1:0]         i_radius_x,
    input  logic [RadiusBits-1:0]         i_radius_y,
    input  logic [3:0]                    i_quadrant_mask,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [OutBits-1:0]     o_span_start_x,
    output logic signed [OutBits-1:0]     o_span_start_y,
    output logic signed [OutBits-1:0]     o_span_end_x,
    output logic signed [OutBits-1:0]     o_span_end_y,
    output logic                          o_is_fill,
    output logic [ColorBits-1:0]          o_pixel_color,
    output logic                          o_last,
    output logic                          o_finished,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [ColorBits-1:0]          i_cfg_data
);
    logic [ColorBits-1:0] r_boundary_color, r_interior_color;
    t_cmd    cmd;
    t_status status;
    logic res_load, res_fill, res_last, res_free;
    logic signed [OutBits-1:0] ax, ay, bx, by;
    logic done_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boundary_color <= ColorBits'(24'h0000FF);
            r_interior_color <= ColorBits'(24'hFFFF00);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CfgBoundary) r_boundary_color <= i_cfg_data;
            if (i_cfg_index == CfgInterior) r_interior_color <= i_cfg_data;
        end
    end

    // the update that follows the emit step ends the ellipse
    assign done_now = status.last_step;

    mesr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_kind     (i_kind),
        .o_ready    (o_ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_res_load (res_load),
        .o_res_fill (res_fill),
        .o_res_last (res_last),
        .i_res_free (res_free)
    );

    mesr_datapath u_dp (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_radius_x      (i_radius_x),
        .i_radius_y      (i_radius_y),
        .i_quadrant_mask (i_quadrant_mask),
        .o_status        (status),
        .o_ax            (ax),
        .o_ay            (ay),
        .o_bx            (bx),
        .o_by            (by)
    );

    mesr_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_load),
        .i_ax       (ax),
        .i_ay       (ay),
        .i_bx       (bx),
        .i_by       (by),
        .i_fill     (res_fill),
        .i_color    (res_fill ? r_interior_color : r_boundary_color),
        .i_last     (res_last),
        .i_done     (done_now),
        .o_free     (res_free),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_ax       (o_span_start_x),
        .o_ay       (o_span_start_y),
        .o_bx       (o_span_end_x),
        .o_by       (o_span_end_y),
        .o_fill     (o_is_fill),
        .o_color    (o_pixel_color),
        .o_last     (o_last),
        .o_done     (o_finished)
    );
endmodule
